// ===== rtl/srs_pkg.sv =====
package srs_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 32;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int LBD_W = 10;
	localparam int LEMMA_W = 24;
	localparam int LIMIT_W = 32;

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	// floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit x.
	localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;
	localparam int DIV100_SHIFT = 37;
	localparam logic [6:0] AVG_NUM = 7'd125;

	// floor(n / 300) == (n * LEMMA_MAGIC) >> LEMMA_SHIFT for every n below 2^25.
	localparam logic [24:0] LEMMA_MAGIC = 25'd28633116;
	localparam int LEMMA_SHIFT = 33;
	localparam logic [8:0] LEMMA_STEP = 9'd300;
	localparam logic [8:0] LEMMA_ROUND = 9'd299;

	localparam int FAST_SHIFT = 5;
	localparam int FAST_GAIN = 15;
	localparam int SLOW_SHIFT = 15;
	localparam int SLOW_GAIN = 5;

	localparam logic [31:0] RST_GEO_FIRST = 32'd100;
	localparam logic [9:0] RST_GROW_MULT = 10'd384;
	localparam logic [31:0] RST_ARITH_FIRST = 32'd100;
	localparam logic [19:0] RST_ARITH_STEP = 20'd100;
	localparam logic [31:0] RST_LEMMA_START = 32'd2000;
	localparam logic [31:0] RST_EMA_START = 32'd16777216;
	localparam logic [4:0] RST_POW_BASE = 5'd2;

	typedef enum logic [1:0] {
		MODE_AVG = 2'd0,
		MODE_ARITH = 2'd1,
		MODE_GEO = 2'd2,
		MODE_LUBY = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE = 4'd0,
		REG_POW_BASE = 4'd1,
		REG_GEO_FIRST = 4'd2,
		REG_GROW_MULT = 4'd3,
		REG_ARITH_FIRST = 4'd4,
		REG_ARITH_STEP = 4'd5,
		REG_LEMMA_START = 4'd6,
		REG_EMA_START = 4'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMA,
		ST_AVG_MUL,
		ST_AVG_CMP,
		ST_LUBY_INIT,
		ST_LUBY_GROW,
		ST_LUBY_SHRINK,
		ST_LUBY_POW,
		ST_LIMIT_CMP,
		ST_GEO_MUL,
		ST_LEMMA_MUL,
		ST_LEMMA_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic ema;
		logic avg_mul;
		logic avg_cmp;
		logic luby_init;
		logic luby_grow;
		logic luby_shrink;
		logic luby_pow;
		logic limit_cmp;
		logic geo_mul;
		logic lemma_mul;
		logic lemma_add;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic grow_more;
		logic shrink_more;
		logic pow_more;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/srs_ctrl.sv =====
module srs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  srs_pkg::status_t status,
	output srs_pkg::cmd_t    cmd
);
	import srs_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EMA;
			end
			ST_EMA: begin
				case (status.mode)
					MODE_AVG: state_next = ST_AVG_MUL;
					MODE_LUBY: state_next = ST_LUBY_INIT;
					default: state_next = ST_LIMIT_CMP;
				endcase
			end
			ST_AVG_MUL: state_next = ST_AVG_CMP;
			ST_AVG_CMP: state_next = ST_LEMMA_MUL;
			ST_LUBY_INIT: state_next = ST_LUBY_GROW;
			ST_LUBY_GROW: begin
				if (!status.grow_more) state_next = ST_LUBY_SHRINK;
			end
			ST_LUBY_SHRINK: begin
				if (!status.shrink_more) state_next = ST_LUBY_POW;
			end
			ST_LUBY_POW: begin
				if (!status.pow_more) state_next = ST_LIMIT_CMP;
			end
			ST_LIMIT_CMP: begin
				if (status.mode == MODE_GEO) state_next = ST_GEO_MUL;
				else state_next = ST_LEMMA_MUL;
			end
			ST_GEO_MUL: state_next = ST_LEMMA_MUL;
			ST_LEMMA_MUL: state_next = ST_LEMMA_ADD;
			ST_LEMMA_ADD: state_next = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EMA: cmd.ema = 1'b1;
			ST_AVG_MUL: cmd.avg_mul = 1'b1;
			ST_AVG_CMP: cmd.avg_cmp = 1'b1;
			ST_LUBY_INIT: cmd.luby_init = 1'b1;
			ST_LUBY_GROW: cmd.luby_grow = 1'b1;
			ST_LUBY_SHRINK: cmd.luby_shrink = 1'b1;
			ST_LUBY_POW: cmd.luby_pow = 1'b1;
			ST_LIMIT_CMP: cmd.limit_cmp = 1'b1;
			ST_GEO_MUL: cmd.geo_mul = 1'b1;
			ST_LEMMA_MUL: cmd.lemma_mul = 1'b1;
			ST_LEMMA_ADD: cmd.lemma_add = 1'b1;
			ST_DONE: cmd.load_out = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/srs_dp.sv =====
module srs_dp #(
	parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [srs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [srs_pkg::LBD_W-1:0]        lbd,
	input  logic [srs_pkg::LEMMA_W-1:0]      lemma_count,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic                             restart_now,
	output logic                             reduce_request,
	output logic [srs_pkg::LIMIT_W-1:0]      active_limit,
	input  srs_pkg::cmd_t                    cmd,
	output srs_pkg::status_t                 status
);
	import srs_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	// Configuration that is read during a conflict.
	mode_t       mode_q;
	logic [4:0]  pow_base_q;
	logic [9:0]  grow_mult_q;
	logic [19:0] arith_step_q;

	// Scheduler state.
	logic [31:0]            fast_q;
	logic [31:0]            slow_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [31:0]            luby_pos_q;
	logic [31:0]            geo_limit_q;
	logic [31:0]            arith_limit_q;
	logic [31:0]            lemma_limit_q;

	// Working registers of one conflict.
	logic [LBD_W-1:0]   lbd_q;
	logic [LEMMA_W-1:0] lemmas_q;
	logic [62:0]        avg_prod_q;
	logic [31:0]        lx_q;
	logic [32:0]        lsize_q;
	logic [5:0]         lseq_q;
	logic [31:0]        pow_q;
	logic [5:0]         pexp_q;
	logic [31:0]        limit_q;
	logic               restart_q;
	logic               reduce_q;
	logic [49:0]        lemma_prod_q;

	logic        out_valid_q;
	logic        out_restart_q;
	logic        out_reduce_q;
	logic [31:0] out_limit_q;

	logic [32:0]        fast_sum;
	logic [32:0]        slow_sum;
	logic [32:0]        avg_bound;
	logic [32:0]        luby_half;
	logic [36:0]        pow_prod;
	logic [31:0]        limit_sel;
	logic               limit_hit;
	logic [41:0]        geo_prod;
	logic [32:0]        arith_sum;
	logic               reduce_hit;
	logic [24:0]        lemma_round;
	logic [25:0]        lemma_inc;
	logic [32:0]        lemma_sum;

	always_comb begin
		fast_sum = {1'b0, fast_q} - 33'(fast_q >> FAST_SHIFT) + (33'(lbd_q) << FAST_GAIN);
		slow_sum = {1'b0, slow_q} - 33'(slow_q >> SLOW_SHIFT) + (33'(lbd_q) << SLOW_GAIN);
		avg_bound = 33'(avg_prod_q[62:DIV100_SHIFT]) * 33'(AVG_NUM);
		luby_half = (lsize_q - 33'd1) >> 1;
		pow_prod = 37'(pow_q) * 37'(pow_base_q);
		case (mode_q)
			MODE_ARITH: limit_sel = arith_limit_q;
			MODE_GEO: limit_sel = geo_limit_q;
			default: limit_sel = pow_q;
		endcase
		limit_hit = CMP_W'(count_q) >= CMP_W'(limit_sel);
		geo_prod = 42'(geo_limit_q) * 42'(grow_mult_q);
		arith_sum = {1'b0, arith_limit_q} + 33'(arith_step_q);
		reduce_hit = restart_q && (32'(lemmas_q) > lemma_limit_q);
		lemma_round = 25'(lemmas_q) - 25'(lemma_limit_q[23:0]) + 25'(LEMMA_ROUND);
		lemma_inc = 26'(lemma_prod_q[49:LEMMA_SHIFT]) * 26'(LEMMA_STEP);
		lemma_sum = {1'b0, lemma_limit_q} + 33'(lemma_inc);
	end

	always_comb begin
		status.mode = mode_q;
		status.grow_more = lsize_q < ({1'b0, lx_q} + 33'd1);
		status.shrink_more = (lsize_q > 33'd1) && ((lsize_q - 33'd1) != {1'b0, lx_q});
		status.pow_more = (pexp_q != '0) && (pow_q != MAX32) && (pow_q != '0);
		status.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_AVG;
			pow_base_q <= RST_POW_BASE;
			grow_mult_q <= RST_GROW_MULT;
			arith_step_q <= RST_ARITH_STEP;
			fast_q <= RST_EMA_START;
			slow_q <= RST_EMA_START;
			count_q <= '0;
			luby_pos_q <= '0;
			geo_limit_q <= RST_GEO_FIRST;
			arith_limit_q <= RST_ARITH_FIRST;
			lemma_limit_q <= RST_LEMMA_START;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ema) begin
				fast_q <= fast_sum[32] ? MAX32 : fast_sum[31:0];
				slow_q <= slow_sum[32] ? MAX32 : slow_sum[31:0];
				if (count_q != '1) count_q <= count_q + 1'b1;
			end
			if (cmd.avg_cmp && ({1'b0, fast_q} > avg_bound)) begin
				fast_q <= avg_bound[31:0];
			end
			if (cmd.limit_cmp && limit_hit) begin
				count_q <= '0;
				if (mode_q == MODE_ARITH) begin
					arith_limit_q <= arith_sum[32] ? MAX32 : arith_sum[31:0];
				end
				if (mode_q == MODE_LUBY && luby_pos_q != MAX32) begin
					luby_pos_q <= luby_pos_q + 32'd1;
				end
			end
			if (cmd.geo_mul && restart_q) begin
				geo_limit_q <= (|geo_prod[41:40]) ? MAX32 : geo_prod[39:8];
			end
			if (cmd.lemma_add && reduce_q) begin
				lemma_limit_q <= lemma_sum[32] ? MAX32 : lemma_sum[31:0];
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
					REG_POW_BASE: pow_base_q <= cfg_data[4:0];
					REG_GEO_FIRST: geo_limit_q <= cfg_data;
					REG_GROW_MULT: grow_mult_q <= cfg_data[9:0];
					REG_ARITH_FIRST: arith_limit_q <= cfg_data;
					REG_ARITH_STEP: arith_step_q <= cfg_data[19:0];
					REG_LEMMA_START: lemma_limit_q <= 32'(cfg_data[23:0]);
					REG_EMA_START: begin
						fast_q <= 32'(cfg_data[30:0]);
						slow_q <= 32'(cfg_data[30:0]);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lbd_q <= lbd;
			lemmas_q <= lemma_count;
		end
		if (cmd.avg_mul) begin
			avg_prod_q <= 63'(slow_q) * 63'(DIV100_MAGIC);
		end
		if (cmd.avg_cmp) begin
			restart_q <= {1'b0, fast_q} > avg_bound;
			limit_q <= '0;
		end
		if (cmd.luby_init) begin
			lx_q <= luby_pos_q;
			lsize_q <= 33'd1;
			lseq_q <= '0;
		end
		if (cmd.luby_grow && status.grow_more) begin
			lsize_q <= {lsize_q[31:0], 1'b1};
			lseq_q <= lseq_q + 6'd1;
		end
		if (cmd.luby_shrink) begin
			if (status.shrink_more) begin
				lsize_q <= luby_half;
				lseq_q <= lseq_q - 6'd1;
				if ({1'b0, lx_q} >= luby_half) lx_q <= lx_q - luby_half[31:0];
			end else begin
				pow_q <= 32'd1;
				pexp_q <= lseq_q;
			end
		end
		if (cmd.luby_pow && status.pow_more) begin
			pow_q <= (|pow_prod[36:32]) ? MAX32 : pow_prod[31:0];
			pexp_q <= pexp_q - 6'd1;
		end
		if (cmd.limit_cmp) begin
			restart_q <= limit_hit;
			limit_q <= limit_sel;
		end
		if (cmd.lemma_mul) begin
			reduce_q <= reduce_hit;
			lemma_prod_q <= 50'(lemma_round) * 50'(LEMMA_MAGIC);
		end
		if (cmd.load_out) begin
			out_restart_q <= restart_q;
			out_reduce_q <= reduce_q;
			out_limit_q <= limit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign restart_now = out_restart_q;
	assign reduce_request = out_reduce_q;
	assign active_limit = out_limit_q;

endmodule

// ===== rtl/sat_restart_scheduler.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// input    | in        | in_valid / in_ready  | lbd[9:0], lemma_count[23:0]
// output   | out       | out_valid / out_ready| restart_now, reduce_request, active_limit
// config   | in        | cfg_we (no wait)     | cfg_index[3:0], cfg_data[31:0]
//
// One conflict is worked on at a time; the next one is accepted as soon as the previous
// result has moved into the output register, even while that result is still waiting.
// Luby mode takes longest: it adds a Luby term search of G grow and S shrink steps, each
// about log2(position + 2) in number, and P multiplies of the saturating power (at most
// the exponent of the term, stopping early once the power saturates). The Luby sequencer
// takes one grow, shrink or multiply step per cycle.
// Reset is asynchronous and active low and loads every limit and average with its start
// value; there is no clearing pass. A stalled output holds the finished result and keeps the next one in ST_DONE.
module sat_restart_scheduler #(
	parameter int COUNT_WIDTH = srs_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [srs_pkg::LBD_W-1:0]       lbd,
	input  logic [srs_pkg::LEMMA_W-1:0]     lemma_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            restart_now,
	output logic                            reduce_request,
	output logic [srs_pkg::LIMIT_W-1:0]     active_limit
);
	import srs_pkg::*;

	// The controller steps through the phases of one conflict: average update, then
	// either the moving-average bound or the conflict-limit check (with the Luby term
	// search and power in front of it in Luby mode, and the geometric limit update after it
	// in geometric mode), then the lemma limit update and finally the hand-over into the output register.
	cmd_t    cmd;
	status_t status;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the scheduler state and the output register.
	// Divisions by 100 and by 300 are done as reciprocal multiplies, each in its own cycle.
	srs_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.lbd            (lbd),
		.lemma_count    (lemma_count),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.restart_now    (restart_now),
		.reduce_request (reduce_request),
		.active_limit   (active_limit),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

// ===== rtl/srs_checker.sv =====
module srs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            restart_now,
	input logic                            reduce_request,
	input logic [srs_pkg::LIMIT_W-1:0]     active_limit
);
	import srs_pkg::*;

	// Transactions accepted on the input and not yet delivered on the output.
	logic [1:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(restart_now)
			&& $stable(reduce_request) && $stable(active_limit))
		else $error("output transaction changed while stalled");

	a_reduce_needs_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!reduce_request || restart_now))
		else $error("reduction requested without a restart");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !in_ready)
		else $error("input accepted while a conflict is in work");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown without an accepted conflict");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two conflicts outstanding");

endmodule

bind sat_restart_scheduler srs_checker u_srs_checker (.*);
